FILE: rtl/mstk_pkg.sv
package mstk_pkg;

  // Fixed widths of the transfer fields.
  localparam int unsigned NodeW     = 10;
  localparam int unsigned WeightInW = 16;
  localparam int unsigned TotalW    = 26;

  // Defaults for the top-level parameters.
  localparam int unsigned DefMaxNodes   = 1024;
  localparam int unsigned DefMaxEdges   = 8192;
  localparam int unsigned DefWeightBits = 16;

  // Node count after reset.
  localparam logic [NodeW-1:0] NodeCountReset = NodeW'(1);

  // One edge as it arrives.
  typedef struct packed {
    logic [NodeW-1:0]     node_a;
    logic [NodeW-1:0]     node_b;
    logic [WeightInW-1:0] edge_weight;
    logic                 last_edge;
  } mstk_in_t;

  // One result.
  typedef struct packed {
    logic [TotalW-1:0] total_weight;
    logic              spanning;
  } mstk_out_t;

endpackage

FILE: rtl/mstk_ram.sv
module mstk_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/min_spanning_tree_kruskal.sv
// Edges are taken one per cycle while the block is idle; kept edges are written to the first edge memory.
// After the last edge: a parent-table clearing pass over all MAX_NODES entries, a bottom-up
// merge sort over two ping-pong edge memories, then, until the tree is complete, for each edge a
// fetch, a root walk with path compression from each endpoint, and a union when the roots differ.
// Reset clears all control state and sets the node count to one; the parent table is rebuilt by the clearing pass.
// Input transfers are stalled from the last edge until the result is registered.
module min_spanning_tree_kruskal
  import mstk_pkg::*;
#(
  parameter int unsigned MAX_NODES   = DefMaxNodes,
  parameter int unsigned MAX_EDGES   = DefMaxEdges,
  parameter int unsigned WEIGHT_BITS = DefWeightBits
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  mstk_in_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output mstk_out_t        out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [NodeW-1:0] cfg_data_i
);

  localparam int unsigned NB = $clog2(MAX_NODES);
  localparam int unsigned EA = $clog2(MAX_EDGES);
  localparam int unsigned CW = EA + 2;
  localparam int unsigned EW = 2 * NodeW + WEIGHT_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_MRG_RD, S_MRG_WR, S_EDGE_RD,
    S_EDGE_GET, S_FIND, S_COMP, S_UNION, S_DONE
  } state_e;

  state_e            state_q, state_d;
  logic [NodeW-1:0]  node_count_q, node_count_d;
  logic [CW-1:0]     edge_cnt_q, edge_cnt_d;
  logic [NB-1:0]     clr_q, clr_d;
  logic [CW-1:0]     width_q, width_d, hi_q, hi_d, mid_q, mid_d;
  logic [CW-1:0]     i_q, i_d, j_q, j_d, k_q, k_d;
  logic              src_q, src_d;
  logic [CW-1:0]     idx_q, idx_d;
  logic [NodeW-1:0]  acc_q, acc_d;
  logic [TotalW-1:0] sum_q, sum_d;
  logic [NodeW-1:0]  ea_q, ea_d, eb_q, eb_d;
  logic [WEIGHT_BITS-1:0] ew_q, ew_d;
  logic [NB-1:0]     v_q, v_d, root_q, root_d, ra_q, ra_d;
  logic              side_q, side_d;
  logic              out_valid_q, out_valid_d;
  mstk_out_t         out_q, out_d;

  // Edge memories: two ping-pong buffers, each kept as two copies for two reads.
  logic [1:0]    buf_we;
  logic [EA-1:0] buf_waddr;
  logic [EW-1:0] buf_wdata;
  logic [EA-1:0] raddr_a, raddr_b;
  logic [EW-1:0] rd_a [2];
  logic [EW-1:0] rd_b [2];

  // Parent table memory.
  logic          par_we;
  logic [NB-1:0] par_waddr, par_wdata, par_raddr, par_rdata;

  for (genvar g = 0; g < 2; g++) begin : g_buf
    mstk_ram #(.Width(EW), .Depth(MAX_EDGES)) u_copy_a (
      .clk_i, .we_i(buf_we[g]), .waddr_i(buf_waddr), .wdata_i(buf_wdata),
      .raddr_i(raddr_a), .rdata_o(rd_a[g])
    );
    mstk_ram #(.Width(EW), .Depth(MAX_EDGES)) u_copy_b (
      .clk_i, .we_i(buf_we[g]), .waddr_i(buf_waddr), .wdata_i(buf_wdata),
      .raddr_i(raddr_b), .rdata_o(rd_b[g])
    );
  end

  mstk_ram #(.Width(NB), .Depth(MAX_NODES)) u_parent (
    .clk_i, .we_i(par_we), .waddr_i(par_waddr), .wdata_i(par_wdata),
    .raddr_i(par_raddr), .rdata_o(par_rdata)
  );

  logic [EW-1:0]          rec_i, rec_j;
  logic [WEIGHT_BITS-1:0] w_i, w_j;
  logic                   take_j;
  logic                   edge_ok;
  logic [NodeW-1:0]       need;
  logic [CW-1:0]          w2, t_mid, t_hi;

  assign rec_i = rd_a[src_q];
  assign rec_j = rd_b[src_q];
  assign w_i   = rec_i[WEIGHT_BITS-1:0];
  assign w_j   = rec_j[WEIGHT_BITS-1:0];
  assign need  = node_count_q - NodeW'(1);

  // An edge is kept when both endpoints are valid node numbers and there is room.
  assign edge_ok = (in_data_i.node_a != '0) && (in_data_i.node_a <= node_count_q) &&
                   (32'(in_data_i.node_a) < MAX_NODES) &&
                   (in_data_i.node_b != '0) && (in_data_i.node_b <= node_count_q) &&
                   (32'(in_data_i.node_b) < MAX_NODES) &&
                   (32'(edge_cnt_q) < MAX_EDGES);

  always_comb begin
    state_d      = state_q;
    node_count_d = node_count_q;
    edge_cnt_d   = edge_cnt_q;
    clr_d        = clr_q;
    width_d      = width_q;
    hi_d         = hi_q;
    mid_d        = mid_q;
    i_d          = i_q;
    j_d          = j_q;
    k_d          = k_q;
    src_d        = src_q;
    idx_d        = idx_q;
    acc_d        = acc_q;
    sum_d        = sum_q;
    ea_d         = ea_q;
    eb_d         = eb_q;
    ew_d         = ew_q;
    v_d          = v_q;
    root_d       = root_q;
    ra_d         = ra_q;
    side_d       = side_q;
    out_valid_d  = out_valid_q & out_stall_i;
    out_d        = out_q;
    buf_we       = 2'b00;
    buf_waddr    = edge_cnt_q[EA-1:0];
    buf_wdata    = {in_data_i.node_a, in_data_i.node_b, WEIGHT_BITS'(in_data_i.edge_weight)};
    raddr_a      = i_q[EA-1:0];
    raddr_b      = j_q[EA-1:0];
    par_we       = 1'b0;
    par_waddr    = clr_q;
    par_wdata    = clr_q;
    par_raddr    = v_q;
    take_j       = 1'b0;
    w2           = width_q << 1;
    t_mid        = '0;
    t_hi         = '0;

    // Configuration transfer.
    if (cfg_valid_i) begin
      node_count_d = cfg_data_i;
    end

    case (state_q)
      // Store incoming edges in the first buffer.
      S_IDLE: begin
        if (in_valid_i) begin
          if (edge_ok) begin
            buf_we[0]  = 1'b1;
            edge_cnt_d = edge_cnt_q + CW'(1);
          end
          if (in_data_i.last_edge) begin
            clr_d   = '0;
            acc_d   = '0;
            sum_d   = '0;
            src_d   = 1'b0;
            state_d = S_CLEAR;
          end
        end
      end

      // Every node becomes its own root; then set up a merge pass, or go to the edge loop or the result.
      S_CLEAR: begin
        par_we = 1'b1;
        clr_d  = clr_q + NB'(1);
        idx_d  = '0;
        if (clr_q == NB'(MAX_NODES - 1)) begin
          if (node_count_q == '0) begin
            state_d = S_DONE;
          end else if (edge_cnt_q <= CW'(1)) begin
            state_d = S_EDGE_RD;
          end else begin
            width_d = CW'(1);
            mid_d   = CW'(1);
            hi_d    = (edge_cnt_q > CW'(2)) ? CW'(2) : edge_cnt_q;
            i_d     = '0;
            j_d     = CW'(1);
            k_d     = '0;
            state_d = S_MRG_RD;
          end
        end
      end

      // Read both run heads.
      S_MRG_RD: begin
        state_d = S_MRG_WR;
      end

      // Move the smaller head to the other buffer and advance.
      S_MRG_WR: begin
        take_j = (i_q >= mid_q) || ((j_q < hi_q) && (w_j < w_i));
        buf_we[~src_q] = 1'b1;
        buf_waddr      = k_q[EA-1:0];
        buf_wdata      = take_j ? rec_j : rec_i;
        if (take_j) begin
          j_d = j_q + CW'(1);
        end else begin
          i_d = i_q + CW'(1);
        end
        k_d     = k_q + CW'(1);
        state_d = S_MRG_RD;
        if (k_q + CW'(1) == edge_cnt_q) begin
          // End of a pass: double the run length and swap buffers.
          src_d   = ~src_q;
          width_d = w2;
          if (w2 >= edge_cnt_q) begin
            state_d = S_EDGE_RD;
          end else begin
            t_mid = (w2 < edge_cnt_q) ? w2 : edge_cnt_q;
            t_hi  = ((w2 << 1) < edge_cnt_q) ? (w2 << 1) : edge_cnt_q;
            mid_d = t_mid;
            hi_d  = t_hi;
            i_d   = '0;
            j_d   = t_mid;
            k_d   = '0;
          end
        end else if (k_q + CW'(1) == hi_q) begin
          // Next pair of runs within this pass.
          t_mid = ((hi_q + width_q) < edge_cnt_q) ? (hi_q + width_q) : edge_cnt_q;
          t_hi  = ((t_mid + width_q) < edge_cnt_q) ? (t_mid + width_q) : edge_cnt_q;
          mid_d = t_mid;
          hi_d  = t_hi;
          i_d   = hi_q;
          j_d   = t_mid;
        end
      end

      // Fetch the next sorted edge while the tree is incomplete.
      S_EDGE_RD: begin
        raddr_a = idx_q[EA-1:0];
        if ((idx_q < edge_cnt_q) && (acc_q < need)) begin
          state_d = S_EDGE_GET;
        end else begin
          state_d = S_DONE;
        end
      end

      // Latch the edge and start walking up from its first endpoint.
      S_EDGE_GET: begin
        ea_d      = rec_i[EW-1 -: NodeW];
        eb_d      = rec_i[WEIGHT_BITS +: NodeW];
        ew_d      = w_i;
        v_d       = NB'(rec_i[EW-1 -: NodeW]);
        par_raddr = NB'(rec_i[EW-1 -: NodeW]);
        side_d    = 1'b0;
        state_d   = S_FIND;
      end

      // Follow parent links, one hop a cycle, until a node is its own parent.
      S_FIND: begin
        if (par_rdata == v_q) begin
          root_d    = v_q;
          v_d       = side_q ? NB'(eb_q) : NB'(ea_q);
          par_raddr = side_q ? NB'(eb_q) : NB'(ea_q);
          state_d   = S_COMP;
        end else begin
          v_d       = par_rdata;
          par_raddr = par_rdata;
        end
      end

      // Path compression: point every node on the path straight at the root.
      S_COMP: begin
        if (par_rdata == root_q) begin
          if (!side_q) begin
            ra_d      = root_q;
            side_d    = 1'b1;
            v_d       = NB'(eb_q);
            par_raddr = NB'(eb_q);
            state_d   = S_FIND;
          end else begin
            state_d = S_UNION;
          end
        end else begin
          par_we    = 1'b1;
          par_waddr = v_q;
          par_wdata = root_q;
          v_d       = par_rdata;
          par_raddr = par_rdata;
        end
      end

      // Join the two trees when the roots differ.
      S_UNION: begin
        if (ra_q != root_q) begin
          par_we    = 1'b1;
          par_waddr = ra_q;
          par_wdata = root_q;
          acc_d     = acc_q + NodeW'(1);
          sum_d     = sum_q + TotalW'(ew_q);
        end
        idx_d   = idx_q + CW'(1);
        state_d = S_EDGE_RD;
      end

      // Register the result once the output stage is free.
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          if ((node_count_q != '0) && (acc_q == need)) begin
            out_d.total_weight = sum_q;
            out_d.spanning     = 1'b1;
          end else begin
            out_d.total_weight = '0;
            out_d.spanning     = 1'b0;
          end
          edge_cnt_d = '0;
          state_d    = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      node_count_q <= NodeCountReset;
      edge_cnt_q   <= '0;
      clr_q        <= '0;
      width_q      <= '0;
      hi_q         <= '0;
      mid_q        <= '0;
      i_q          <= '0;
      j_q          <= '0;
      k_q          <= '0;
      src_q        <= 1'b0;
      idx_q        <= '0;
      acc_q        <= '0;
      sum_q        <= '0;
      ea_q         <= '0;
      eb_q         <= '0;
      ew_q         <= '0;
      v_q          <= '0;
      root_q       <= '0;
      ra_q         <= '0;
      side_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      state_q      <= state_d;
      node_count_q <= node_count_d;
      edge_cnt_q   <= edge_cnt_d;
      clr_q        <= clr_d;
      width_q      <= width_d;
      hi_q         <= hi_d;
      mid_q        <= mid_d;
      i_q          <= i_d;
      j_q          <= j_d;
      k_q          <= k_d;
      src_q        <= src_d;
      idx_q        <= idx_d;
      acc_q        <= acc_d;
      sum_q        <= sum_d;
      ea_q         <= ea_d;
      eb_q         <= eb_d;
      ew_q         <= ew_d;
      v_q          <= v_d;
      root_q       <= root_d;
      ra_q         <= ra_d;
      side_q       <= side_d;
      out_valid_q  <= out_valid_d;
      out_q        <= out_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

endmodule
